// ===== rtl/lpcc_pkg.sv =====
// lpcc_pkg: shared types and codes for the lidar point colouriser
// used by lpcc_front, lpcc_back and the core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lpcc_pkg;

  // widest pixel axis index that any configuration can need (8192 columns or rows)
  localparam int AXIS_BITS = 13;

  typedef enum logic [0:0] {
    OP_WRITE   = 1'b0,
    OP_PROJECT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_COLORED = 3'd0,
    ST_ORIGIN  = 3'd1,
    ST_NONPOS  = 3'd2,
    ST_OFF     = 3'd3,
    ST_BLACK   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_ROW0_01 = 3'd0,
    REG_ROW0_23 = 3'd1,
    REG_ROW1_01 = 3'd2,
    REG_ROW1_23 = 3'd3,
    REG_ROW2_01 = 3'd4,
    REG_ROW2_23 = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } reg_e;

  // command from the projection front to the pixel back
  typedef struct packed {
    op_e                  op;
    logic                 in_store;
    status_e              status;
    logic [AXIS_BITS-1:0] row;
    logic [AXIS_BITS-1:0] col;
    logic [23:0]          rgb;
  } cmd_t;

  // finished result
  typedef struct packed {
    status_e              status;
    logic [23:0]          rgb;
    logic [AXIS_BITS-1:0] row;
    logic [AXIS_BITS-1:0] col;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/lpcc_ram.sv =====
// lpcc_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lpcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/lpcc_fifo.sv =====
// lpcc_fifo: small register queue with occupancy count
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lpcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/lpcc_div.sv =====
// lpcc_div: pipelined restoring divider, one quotient bit per stage
// returns the low quotient bits and an overflow flag; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lpcc_div #(
  parameter int NW = 49,
  parameter int QB = 10
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [NW-1:0] den_i,
  output logic      [QB-1:0] quo_o,
  output logic               ovf_o
);

  logic [NW-1:0] rem_q [QB+1];
  logic [NW-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];

  // first stage: quotient too large for QB bits
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= {{QB{1'b0}}, num_i} >= {den_i, {QB{1'b0}}};
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int BIT = QB - k;
    logic [NW+QB-1:0] dsh;
    logic             take;

    assign dsh  = {{QB{1'b0}}, den_q[k-1]} << BIT;
    assign take = {{QB{1'b0}}, rem_q[k-1]} >= dsh;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? rem_q[k-1] - dsh[NW-1:0] : rem_q[k-1];
      den_q[k] <= den_q[k-1];
      quo_q[k] <= quo_q[k-1] | (QB'(take) << BIT);
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

`default_nettype wire

// ===== rtl/lpcc_front.sv =====
// lpcc_front: accepts items, classifies them and projects points to pixels
// depends on lpcc_pkg and lpcc_div
`timescale 1ns / 1ps
`default_nettype none

module lpcc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic                            operation_i,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]   pixel_row_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]    pixel_col_i,
  input  wire logic [23:0]                     pixel_rgb_i,
  input  wire logic signed [31:0]              point_x_i,
  input  wire logic signed [31:0]              point_y_i,
  input  wire logic signed [31:0]              point_z_i,
  input  wire logic [5:0][63:0]                coef_i,
  input  wire logic [10:0]                     width_i,
  input  wire logic [9:0]                      height_i,
  output logic                                 cmd_valid_o,
  output lpcc_pkg::cmd_t                       cmd_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SW  = 66 - FRAC_BITS;
  localparam int NW  = SW - 1;
  localparam int QB  = (CW > RW) ? CW : RW;
  localparam int LAT = QB + 1;
  localparam int AB  = lpcc_pkg::AXIS_BITS;

  typedef struct packed {
    lpcc_pkg::op_e op;
    logic          in_store;
    logic          origin;
    logic [AB-1:0] prow;
    logic [AB-1:0] pcol;
    logic [23:0]   rgb;
  } side_t;

  typedef struct packed {
    side_t             base;
    lpcc_pkg::status_e status;
    logic              neg_u;
    logic              neg_v;
  } dside_t;

  // accept stage
  side_t              side_in;
  logic               a_valid_q;
  side_t              a_side_q;
  logic signed [31:0] a_pt_q [3];

  always_comb begin
    side_in.op       = lpcc_pkg::op_e'(operation_i);
    side_in.in_store = (32'(pixel_row_i) < 32'(MAX_HEIGHT)) &&
                       (32'(pixel_col_i) < 32'(MAX_WIDTH));
    side_in.origin   = (point_x_i == '0) && (point_y_i == '0) && (point_z_i == '0);
    side_in.prow     = AB'(pixel_row_i);
    side_in.pcol     = AB'(pixel_col_i);
    side_in.rgb      = pixel_rgb_i;
  end

  always_ff @(posedge clk_i) begin
    a_side_q  <= side_in;
    a_pt_q[0] <= point_x_i;
    a_pt_q[1] <= point_y_i;
    a_pt_q[2] <= point_z_i;
  end

  // multiply stage: nine coefficient products
  logic               m_valid_q;
  side_t              m_side_q;
  logic signed [63:0] m_prod_q [3][3];

  always_ff @(posedge clk_i) begin
    m_side_q <= a_side_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_prod_q[r][c] <= $signed(coef_i[2*r + (c >> 1)][32*(c & 1) +: 32]) * a_pt_q[c];
      end
    end
  end

  // partial sums of floored products
  logic              s1_valid_q;
  side_t             s1_side_q;
  logic signed [SW-1:0] s1_a_q [3];
  logic signed [SW-1:0] s1_b_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [63:0]   sh;
    logic signed [SW-1:0] term [3];
    logic        [31:0]   c3;
    s1_side_q <= m_side_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sh      = m_prod_q[r][c] >>> FRAC_BITS;
        term[c] = sh[SW-1:0];
      end
      c3        = coef_i[2*r + 1][63:32];
      s1_a_q[r] <= term[0] + term[1];
      s1_b_q[r] <= term[2] + $signed({{(SW-32){c3[31]}}, c3});
    end
  end

  // full dot products u, v, w
  logic                 s2_valid_q;
  side_t                s2_side_q;
  logic signed [SW-1:0] dot_q [3];

  always_ff @(posedge clk_i) begin
    s2_side_q <= s1_side_q;
    for (int r = 0; r < 3; r++) begin
      dot_q[r] <= s1_a_q[r] + s1_b_q[r];
    end
  end

  // classify and feed the dividers
  dside_t        cls;
  logic          w_pos;
  logic [NW-1:0] num_u, num_v, den;

  always_comb begin
    w_pos      = !dot_q[2][SW-1] && (dot_q[2] != '0);
    cls.base   = s2_side_q;
    cls.neg_u  = dot_q[0][SW-1];
    cls.neg_v  = dot_q[1][SW-1];
    if (s2_side_q.origin) begin
      cls.status = lpcc_pkg::ST_ORIGIN;
    end else if (!w_pos) begin
      cls.status = lpcc_pkg::ST_NONPOS;
    end else begin
      cls.status = lpcc_pkg::ST_COLORED;
    end
    num_u = cls.neg_u ? '0 : dot_q[0][NW-1:0];
    num_v = cls.neg_v ? '0 : dot_q[1][NW-1:0];
    den   = w_pos ? dot_q[2][NW-1:0] : NW'(1);
  end

  logic [QB-1:0] quo_u, quo_v;
  logic          ovf_u, ovf_v;

  lpcc_div #(.NW(NW), .QB(QB)) u_div_col (
    .clk_i (clk_i),
    .num_i (num_u),
    .den_i (den),
    .quo_o (quo_u),
    .ovf_o (ovf_u)
  );

  lpcc_div #(.NW(NW), .QB(QB)) u_div_row (
    .clk_i (clk_i),
    .num_i (num_v),
    .den_i (den),
    .quo_o (quo_v),
    .ovf_o (ovf_v)
  );

  // side information travels beside the dividers
  logic [LAT-1:0] dl_valid_q;
  dside_t         dl_side_q [LAT];

  always_ff @(posedge clk_i) begin
    dl_side_q[0] <= cls;
    for (int k = 1; k < LAT; k++) begin
      dl_side_q[k] <= dl_side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      dl_valid_q  <= '0;
      cmd_valid_o <= 1'b0;
    end else begin
      a_valid_q   <= valid_i;
      m_valid_q   <= a_valid_q;
      s1_valid_q  <= m_valid_q;
      s2_valid_q  <= s1_valid_q;
      dl_valid_q  <= {dl_valid_q[LAT-2:0], s2_valid_q};
      cmd_valid_o <= dl_valid_q[LAT-1];
    end
  end

  // bounds check and command build
  dside_t         fin;
  logic [31:0]    wlim, hlim;
  logic           off;
  lpcc_pkg::cmd_t cmd_d;

  always_comb begin
    fin  = dl_side_q[LAT-1];
    wlim = (32'(width_i) < 32'(MAX_WIDTH)) ? 32'(width_i) : 32'(MAX_WIDTH);
    hlim = (32'(height_i) < 32'(MAX_HEIGHT)) ? 32'(height_i) : 32'(MAX_HEIGHT);
    off  = fin.neg_u || ovf_u || (32'(quo_u) >= wlim) ||
           fin.neg_v || ovf_v || (32'(quo_v) >= hlim);
    cmd_d.op       = fin.base.op;
    cmd_d.in_store = fin.base.in_store;
    cmd_d.rgb      = fin.base.rgb;
    if (fin.base.op == lpcc_pkg::OP_WRITE) begin
      cmd_d.status = lpcc_pkg::ST_COLORED;
      cmd_d.row    = fin.base.prow;
      cmd_d.col    = fin.base.pcol;
    end else begin
      cmd_d.status = (fin.status == lpcc_pkg::ST_COLORED && off) ? lpcc_pkg::ST_OFF
                                                                 : fin.status;
      cmd_d.row    = AB'(quo_v);
      cmd_d.col    = AB'(quo_u);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_o <= cmd_d;
  end

endmodule

`default_nettype wire

// ===== rtl/lpcc_back.sv =====
// lpcc_back: executes commands against the image store and forms results
// depends on lpcc_pkg and lpcc_ram
`timescale 1ns / 1ps
`default_nettype none

module lpcc_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int OUT_DEPTH  = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cmd_empty_i,
  input  wire lpcc_pkg::cmd_t                 cmd_i,
  output logic                                cmd_pop_o,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                res_push_o,
  output lpcc_pkg::res_t                      res_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int AB = lpcc_pkg::AXIS_BITS;

  logic              b1_valid_q;
  lpcc_pkg::status_e b1_status_q;
  logic [AB-1:0]     b1_row_q, b1_col_q;
  logic              room, wr_en;
  logic [AW-1:0]     addr;
  logic [23:0]       pix;

  // a result slot must stay free for the item now reading the store
  assign room      = (32'(out_count_i) + 32'(b1_valid_q)) < 32'(OUT_DEPTH);
  assign cmd_pop_o = !cmd_empty_i && room;
  assign wr_en     = cmd_pop_o && (cmd_i.op == lpcc_pkg::OP_WRITE) && cmd_i.in_store;
  assign addr      = {cmd_i.row[RW-1:0], cmd_i.col[CW-1:0]};

  lpcc_ram #(.WIDTH(24), .DEPTH(2**AW)) u_image (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr),
    .wdata_i (cmd_i.rgb),
    .raddr_i (addr),
    .rdata_o (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= cmd_pop_o && (cmd_i.op == lpcc_pkg::OP_PROJECT);
    end
  end

  always_ff @(posedge clk_i) begin
    b1_status_q <= cmd_i.status;
    b1_row_q    <= cmd_i.row;
    b1_col_q    <= cmd_i.col;
  end

  always_comb begin
    res_o.status = b1_status_q;
    if (b1_status_q == lpcc_pkg::ST_COLORED && pix == '0) begin
      res_o.status = lpcc_pkg::ST_BLACK;
    end
    res_o.rgb = (res_o.status == lpcc_pkg::ST_COLORED) ? pix : '0;
    if (res_o.status == lpcc_pkg::ST_COLORED || res_o.status == lpcc_pkg::ST_BLACK) begin
      res_o.row = b1_row_q;
      res_o.col = b1_col_q;
    end else begin
      res_o.row = '0;
      res_o.col = '0;
    end
  end

  assign res_push_o = b1_valid_q;

endmodule

`default_nettype wire

// ===== rtl/lidar_point_camera_colorizer_core.sv =====
// lidar_point_camera_colorizer_core: top level, configuration registers and queues
// depends on lpcc_pkg, lpcc_fifo, lpcc_front and lpcc_back
//
// Input channel: push/full. operation 0 writes one RGB pixel of the image
// store, operation 1 projects a lidar point through the 3x4 matrix.
// Result channel: empty/pop. One result per projected point, none per pixel
// write; the oldest result sits on the result ports while empty is low.
// Configuration: APB write of 64-bit registers at 8*index; pready is tied high.
// Write configuration only while no item is in flight.
// Throughput: one item per cycle while full is low. QB is the number of quotient
// bits (the larger of log2 of the maximum width and height); the pipelined
// divider spends one stage on each quotient bit.
// Between the projection front and the store back sits a 32-entry command
// queue; full rises once 32 items are accepted but not yet taken by the back.
// When pop stays low, results collect in a 4-entry result queue, then the
// back holds, the command queue fills and full rises; nothing is dropped.
// Reset: matrix cleared, width 1024 and height 512 (register defaults),
// queues emptied. The image store is not cleared and must be written before
// it is read.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_camera_colorizer_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input queue
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          operation_i,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] pixel_row_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  pixel_col_i,
  input  wire logic [7:0]                    pixel_red_i,
  input  wire logic [7:0]                    pixel_green_i,
  input  wire logic [7:0]                    pixel_blue_i,
  input  wire logic signed [31:0]            point_x_i,
  input  wire logic signed [31:0]            point_y_i,
  input  wire logic signed [31:0]            point_z_i,
  // result queue
  output logic                               empty,
  input  wire logic                          pop,
  output logic [2:0]                         status_o,
  output logic [7:0]                         color_red_o,
  output logic [7:0]                         color_green_o,
  output logic [7:0]                         color_blue_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       image_col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]      image_row_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [5:0]                    paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int MID_DEPTH = 32;
  localparam int OUT_DEPTH = 4;
  localparam int MCW       = $clog2(MID_DEPTH+1);
  localparam int OCW       = $clog2(OUT_DEPTH+1);

  // configuration registers
  logic [5:0][63:0]  coef_q;
  logic [10:0]       width_q;
  logic [9:0]        height_q;
  lpcc_pkg::reg_e    cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = lpcc_pkg::reg_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      width_q  <= 11'd1024;
      height_q <= 10'd512;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lpcc_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
        lpcc_pkg::REG_HEIGHT: height_q <= pwdata[9:0];
        default:              coef_q[cfg_idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lpcc_pkg::REG_WIDTH:  prdata = 64'(width_q);
      lpcc_pkg::REG_HEIGHT: prdata = 64'(height_q);
      default:              prdata = coef_q[cfg_idx];
    endcase
  end

  // credit for the command queue: items accepted but not yet taken by the back
  logic           accept;
  logic           mid_pop;
  logic [MCW-1:0] mid_cnt_q, mid_cnt_d;

  assign accept = push && !full;
  assign full   = (mid_cnt_q == MCW'(MID_DEPTH));

  always_comb begin
    mid_cnt_d = mid_cnt_q;
    if (accept && !mid_pop) begin
      mid_cnt_d = mid_cnt_q + 1'b1;
    end else if (!accept && mid_pop) begin
      mid_cnt_d = mid_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_cnt_q <= '0;
    end else begin
      mid_cnt_q <= mid_cnt_d;
    end
  end

  logic           front_valid;
  lpcc_pkg::cmd_t front_cmd, mid_cmd;
  logic           mid_empty;
  logic [MCW-1:0] mid_fill;

  lpcc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .operation_i (operation_i),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .pixel_rgb_i ({pixel_red_i, pixel_green_i, pixel_blue_i}),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .coef_i      (coef_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  lpcc_fifo #(
    .WIDTH ($bits(lpcc_pkg::cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_cmd),
    .pop_i   (mid_pop),
    .rdata_o (mid_cmd),
    .empty_o (mid_empty),
    .count_o (mid_fill)
  );

  logic           out_push;
  lpcc_pkg::res_t back_res, out_res;
  logic [OCW-1:0] out_cnt;

  lpcc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (mid_empty),
    .cmd_i       (mid_cmd),
    .cmd_pop_o   (mid_pop),
    .out_count_i (out_cnt),
    .res_push_o  (out_push),
    .res_o       (back_res)
  );

  lpcc_fifo #(
    .WIDTH ($bits(lpcc_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_res),
    .pop_i   (pop && !empty),
    .rdata_o (out_res),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  assign status_o      = out_res.status;
  assign color_red_o   = out_res.rgb[23:16];
  assign color_green_o = out_res.rgb[15:8];
  assign color_blue_o  = out_res.rgb[7:0];
  assign image_col_o   = out_res.col[CW-1:0];
  assign image_row_o   = out_res.row[RW-1:0];

  // the credit never runs past the command queue depth and covers its fill
  a_mid_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_cnt_q <= MCW'(MID_DEPTH)) && (mid_fill <= mid_cnt_q))
    else $error("command queue credit overrun");

  // the back only pops a command that is there
  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("command popped from empty queue");

  // a result always finds a free slot in the result queue
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> (out_cnt < OCW'(OUT_DEPTH)) || (pop && !empty))
    else $error("result queue overflow");

  // a point not coloured carries no colour
  a_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != lpcc_pkg::ST_COLORED) |->
      (color_red_o == '0 && color_green_o == '0 && color_blue_o == '0))
    else $error("colour on a rejected point");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for the lidar point colouriser core
// depends on lpcc_pkg and lidar_point_camera_colorizer_core; predicts every result itself
`timescale 1ns / 1ps

module tb_top;
  import lpcc_pkg::*;

  localparam int FRAC = 16;
  localparam int STORE_W = 1024;
  localparam int STORE_H = 512;
  localparam int SETTLE = 40;

  typedef struct packed {
    op_e                op;
    logic [8:0]         prow;
    logic [9:0]         pcol;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } item_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    status_e st;
  } dir_row_t;

  typedef struct packed {
    status_e    st;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] col;
    logic [8:0] row;
  } colour_t;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic operation_i;
  logic [8:0] pixel_row_i;
  logic [9:0] pixel_col_i;
  logic [7:0] pixel_red_i, pixel_green_i, pixel_blue_i;
  logic signed [31:0] point_x_i, point_y_i, point_z_i;
  logic [2:0] status_o;
  logic [7:0] color_red_o, color_green_o, color_blue_o;
  logic [9:0] image_col_o;
  logic [8:0] image_row_o;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;

  lidar_point_camera_colorizer_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .operation_i(operation_i), .pixel_row_i(pixel_row_i), .pixel_col_i(pixel_col_i),
    .pixel_red_i(pixel_red_i), .pixel_green_i(pixel_green_i), .pixel_blue_i(pixel_blue_i),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .point_z_i(point_z_i),
    .empty(empty), .pop(pop), .status_o(status_o),
    .color_red_o(color_red_o), .color_green_o(color_green_o), .color_blue_o(color_blue_o),
    .image_col_o(image_col_o), .image_row_o(image_row_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block's registers and image store
  logic [63:0] coef_regs [6];
  logic [10:0] cfg_width;
  logic [9:0]  cfg_height;
  logic [23:0] pixel_shadow [int];

  colour_t expected_colours[$];
  int mismatches;
  int status_seen [5];
  int send_idle_pct, recv_stall_pct;
  logic hold_rx, hold_go;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic longint coef_of(input int r, input int c);
    logic [63:0] rv;
    rv = coef_regs[r * 2 + c / 2];
    return (c % 2) ? longint'(signed'(rv[63:32])) : longint'(signed'(rv[31:0]));
  endfunction

  function automatic longint row_sum(input int r, input longint x, input longint y,
                                     input longint z);
    return ((coef_of(r, 0) * x) >>> FRAC) + ((coef_of(r, 1) * y) >>> FRAC) +
           ((coef_of(r, 2) * z) >>> FRAC) + coef_of(r, 3);
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    return (n >= 0) ? n / d : -((-n + d - 1) / d);
  endfunction

  // status before the store lookup; colored here just means inside the image
  function automatic status_e project(input item_t it, output longint col, output longint row);
    longint u, v, w, wl, hl;
    col = 0;
    row = 0;
    if (it.x == 0 && it.y == 0 && it.z == 0) return ST_ORIGIN;
    u = row_sum(0, it.x, it.y, it.z);
    v = row_sum(1, it.x, it.y, it.z);
    w = row_sum(2, it.x, it.y, it.z);
    if (w <= 0) return ST_NONPOS;
    col = floor_quot(u, w);
    row = floor_quot(v, w);
    wl = (cfg_width > STORE_W) ? STORE_W : cfg_width;
    hl = (cfg_height > STORE_H) ? STORE_H : cfg_height;
    if (col < 0 || col >= wl || row < 0 || row >= hl) return ST_OFF;
    return ST_COLORED;
  endfunction

  function automatic colour_t colour_point(input item_t it);
    colour_t e;
    longint col, row;
    logic [23:0] pix;
    e = '0;
    e.st = project(it, col, row);
    if (e.st == ST_COLORED) begin
      pix = pixel_shadow.exists(row * STORE_W + col) ? pixel_shadow[row * STORE_W + col] : '0;
      e.col = col[9:0];
      e.row = row[8:0];
      if (pix == 0) e.st = ST_BLACK;
      else {e.red, e.green, e.blue} = pix;
    end
    return e;
  endfunction

  task automatic cfg_write(input reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = val[10:0];
    else if (idx == REG_HEIGHT) cfg_height = val[9:0];
    else coef_regs[idx] = val;
  endtask

  task automatic send_item(input item_t it, input logic typed, input status_e tst);
    colour_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= it.op;
    pixel_row_i <= it.prow;
    pixel_col_i <= it.pcol;
    pixel_red_i <= it.red;
    pixel_green_i <= it.green;
    pixel_blue_i <= it.blue;
    point_x_i <= it.x;
    point_y_i <= it.y;
    point_z_i <= it.z;
    do @(posedge clk_i); while (full);
    if (it.op == OP_WRITE) begin
      pixel_shadow[it.prow * STORE_W + it.pcol] = {it.red, it.green, it.blue};
    end else begin
      e = colour_point(it);
      if (typed) begin
        e = '0;
        e.st = tst;
      end
      expected_colours.insert(expected_colours.size(), e);
    end
  endtask

  // a point may only land on a pixel that has been written
  task automatic send_point(input item_t it);
    item_t wr;
    longint col, row;
    if (project(it, col, row) == ST_COLORED && !pixel_shadow.exists(row * STORE_W + col)) begin
      wr = '0;
      wr.op = OP_WRITE;
      wr.prow = row[8:0];
      wr.pcol = col[9:0];
      if ($urandom_range(4) != 0) {wr.red, wr.green, wr.blue} = 24'($urandom);
      send_item(wr, 1'b0, ST_COLORED);
    end
    send_item(it, 1'b0, ST_COLORED);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // pinhole matrix: u = x + cx*z, v = y + cy*z, w = z + small offset
  task automatic load_pinhole(input logic [63:0] wv, input logic [63:0] hv, input int tw,
                              input int th);
    cfg_write(REG_WIDTH, wv);
    cfg_write(REG_HEIGHT, hv);
    cfg_write(REG_ROW0_01, {32'd0, 32'h0001_0000});
    cfg_write(REG_ROW0_23, {32'd0, 32'(tw / 2) << FRAC});
    cfg_write(REG_ROW1_01, {32'h0001_0000, 32'd0});
    cfg_write(REG_ROW1_23, {32'd0, 32'(th / 2) << FRAC});
    cfg_write(REG_ROW2_01, 64'd0);
    cfg_write(REG_ROW2_23, {32'($urandom_range(2)), 32'h0001_0000});
  endtask

  task automatic random_phase(input int n, input int tw, input int th, input logic noise);
    item_t it;
    int tc, tr, kind;
    longint z;
    for (int i = 0; i < n; i++) begin
      it = '0;
      kind = $urandom_range(99);
      if (kind < 25) begin
        it.op = OP_WRITE;
        it.prow = 9'($urandom);
        it.pcol = 10'($urandom);
        if ($urandom_range(9) != 0) {it.red, it.green, it.blue} = 24'($urandom);
        send_item(it, 1'b0, ST_COLORED);
      end else if (kind < 40 || noise) begin
        it.op = OP_PROJECT;
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        if ($urandom_range(19) == 0) it = '{op: OP_PROJECT, default: '0};
        send_point(it);
      end else begin
        it.op = OP_PROJECT;
        tc = int'($urandom_range(tw + 1)) - 1;
        tr = int'($urandom_range(th + 1)) - 1;
        z = $urandom_range(1, 1 << 20);
        if ($urandom_range(19) == 0) z = -z;
        it.z = 32'(z);
        it.x = 32'(longint'(tc - tw / 2) * z + $urandom_range(32'(z > 0 ? z - 1 : 0)));
        it.y = 32'(longint'(tr - th / 2) * z + $urandom_range(32'(z > 0 ? z - 1 : 0)));
        send_point(it);
      end
    end
    drain();
  endtask

  // result side: compare on every accepted pop, then choose the next pop
  initial begin
    colour_t e;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (expected_colours.size() == 0) begin
          report("unexpected result", status_o, 0);
        end else begin
          e = expected_colours.pop_front();
          if (status_o < 5) status_seen[status_o]++;
          if (status_o != e.st) report("status", status_o, e.st);
          if (color_red_o != e.red) report("red", color_red_o, e.red);
          if (color_green_o != e.green) report("green", color_green_o, e.green);
          if (color_blue_o != e.blue) report("blue", color_blue_o, e.blue);
          if (image_col_o != e.col) report("column", image_col_o, e.col);
          if (image_row_o != e.row) report("row", image_row_o, e.row);
        end
      end
      pop <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the queues fill and full rises
  initial begin
    hold_rx = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    dir_row_t dir_tab [12];
    item_t    wr, pt;
    logic [63:0] rv;
    int tw, th;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = 1'b0;
    pixel_row_i = '0;
    pixel_col_i = '0;
    pixel_red_i = '0;
    pixel_green_i = '0;
    pixel_blue_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int r = 0; r < 6; r++) coef_regs[r] = '0;
    cfg_width = 11'd1024;
    cfg_height = 10'd512;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset matrix is all zero: every non-origin point has zero depth
    wr = '0;
    wr.op = OP_WRITE;
    pt = '0;
    pt.op = OP_PROJECT;
    dir_tab[0] = '{wr, 1'b0, ST_COLORED};
    dir_tab[1] = '{'{OP_WRITE, 9'h1ff, 10'h3ff, 8'hff, 8'hff, 8'hff, 32'd0, 32'd0, 32'd0},
                   1'b0, ST_COLORED};
    dir_tab[2] = '{'{OP_WRITE, 9'h155, 10'h2aa, 8'h55, 8'haa, 8'h01, 32'd0, 32'd0, 32'd0},
                   1'b0, ST_COLORED};
    dir_tab[3] = '{'{OP_WRITE, 9'h0aa, 10'h155, 8'haa, 8'h55, 8'hfe, 32'd0, 32'd0, 32'd0},
                   1'b0, ST_COLORED};
    dir_tab[4] = '{pt, 1'b1, ST_ORIGIN};
    dir_tab[5] = '{'{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'd1, 32'd0, 32'd0},
                   1'b1, ST_NONPOS};
    dir_tab[6] = '{'{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000}, 1'b1, ST_NONPOS};
    dir_tab[7] = '{'{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff}, 1'b1, ST_NONPOS};
    dir_tab[8] = '{'{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0, 32'd1},
                   1'b1, ST_NONPOS};
    dir_tab[9] = '{'{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'd0, 32'hffff_ffff, 32'd0},
                   1'b1, ST_NONPOS};
    dir_tab[10] = '{'{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'h7fff_ffff, 32'd0,
                      32'hffff_0000}, 1'b1, ST_NONPOS};
    dir_tab[11] = '{pt, 1'b1, ST_ORIGIN};
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].st);
    drain();

    // full image, junk above the register widths
    rv = $urandom;
    load_pinhole({rv[31:0], 21'($urandom), 11'd1024}, {rv[31:0], 22'($urandom), 10'd512},
                 1024, 512);
    // a pixel on the far corner, then points aimed at it, at the origin and at the right edge
    send_item('{OP_WRITE, 9'd511, 10'd1023, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0},
              1'b0, ST_COLORED);
    send_point('{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'(511 << FRAC),
                 32'(255 << FRAC), 32'h0001_0000});
    send_point('{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'(-512 << FRAC),
                 32'(-256 << FRAC), 32'h0001_0000});
    send_point('{OP_PROJECT, 9'd0, 10'd0, 8'd0, 8'd0, 8'd0, 32'(512 << FRAC),
                 32'd0, 32'h0001_0000});
    random_phase(250, 1024, 512, 1'b0);

    // single-pixel image
    send_idle_pct = 49;
    load_pinhole(64'd1, 64'd1, 1, 1);
    random_phase(230, 1, 1, 1'b0);

    // zero width: everything off image
    send_idle_pct = 0;
    recv_stall_pct = 49;
    load_pinhole(64'd0, 64'd300, 8, 300);
    random_phase(200, 8, 300, 1'b0);

    // register values beyond the store saturate
    send_idle_pct = 35;
    recv_stall_pct = 35;
    load_pinhole(64'd2047, 64'd1023, 1024, 512);
    random_phase(250, 1024, 512, 1'b0);

    // random small image, with a long receiver hold-off
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tw = $urandom_range(1, 64);
    th = $urandom_range(1, 64);
    load_pinhole(64'(tw), 64'(th), tw, th);
    hold_go = 1'b1;
    random_phase(250, tw, th, 1'b0);

    // fully random matrix
    send_idle_pct = 35;
    recv_stall_pct = 35;
    for (int r = 0; r < 6; r++) cfg_write(reg_e'(r), {$urandom, $urandom});
    random_phase(260, 1024, 512, 1'b1);

    $display("covered %0d colored, %0d origin, %0d zero or negative depth,",
             status_seen[ST_COLORED], status_seen[ST_ORIGIN], status_seen[ST_NONPOS]);
    $display("%0d off image and %0d black pixel results over six matrix settings",
             status_seen[ST_OFF], status_seen[ST_BLACK]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
